>>> sv/lsd_pkg.sv
// shared types, constants and arctangent table of the lens series distortion unit
package lsd_pkg;

    // counter widths: cordic steps up to 32, series terms up to 64
    localparam int STEP_W = 6;
    localparam int TERM_W = 7;

    // cordic start value, gain correction in q4.30
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    // configuration register indexes
    localparam logic [7:0] CFG_INV_LENS_RADIUS  = 8'd0;
    localparam logic [7:0] CFG_LENS_COEFFICIENT = 8'd1;
    localparam logic [7:0] CFG_INV_CHI          = 8'd2;
    localparam logic [7:0] CFG_TERM_COUNT       = 8'd3;

    // configuration register file contents
    typedef struct packed {
        logic        [31:0] inv_lens_radius;
        logic signed [31:0] lens_coefficient;
        logic        [31:0] inv_chi;
        logic        [5:0]  term_count;
    } t_cfg;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic cordic;
        logic quad;
        logic pgen;
        logic term_mul;
        logic term_add;
        logic scale_mul;
        logic scale_fin;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic cordic_last;
        logic no_terms;
        logic term_last;
        logic out_free;
    } t_stat;

    // arctangent of 2^-i in turns, 32-bit
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

>>> sv/lsd_ctrl.sv
// sequencing state machine of the lens series distortion unit
module lsd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lsd_pkg::t_stat i_stat,
    output lsd_pkg::t_cmd  o_cmd
);
    import lsd_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CORDIC = 8'b0000_0010,
        S_QUAD   = 8'b0000_0100,
        S_PGEN   = 8'b0000_1000,
        S_TMUL   = 8'b0001_0000,
        S_TADD   = 8'b0010_0000,
        S_SMUL   = 8'b0100_0000,
        S_SFIN   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CORDIC;
                end
            end
            S_CORDIC: begin
                o_cmd.cordic = 1'b1;
                if (i_stat.cordic_last) begin
                    n_state = S_QUAD;
                end
            end
            S_QUAD: begin
                o_cmd.quad = 1'b1;
                n_state    = S_PGEN;
            end
            S_PGEN: begin
                o_cmd.pgen = 1'b1;
                n_state    = i_stat.no_terms ? S_SMUL : S_TMUL;
            end
            S_TMUL: begin
                o_cmd.term_mul = 1'b1;
                n_state        = S_TADD;
            end
            S_TADD: begin
                o_cmd.term_add = 1'b1;
                n_state        = i_stat.term_last ? S_SMUL : S_TMUL;
            end
            S_SMUL: begin
                o_cmd.scale_mul = 1'b1;
                n_state         = S_SFIN;
            end
            S_SFIN: begin
                if (i_stat.out_free) begin
                    o_cmd.scale_fin = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/lsd_dpath.sv
// arithmetic datapath: cordic, series power loop, output scaling and result register
module lsd_dpath #(
    parameter int MAX_TERMS    = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lsd_pkg::t_cmd       i_cmd,
    output lsd_pkg::t_stat      o_stat,
    input  lsd_pkg::t_cfg       i_cfg,
    input  logic [23:0]         i_radius,
    input  logic [15:0]         i_angle,
    output logic signed [31:0]  o_source_x,
    output logic signed [31:0]  o_source_y,
    output logic                o_saturated,
    output logic                o_valid,
    input  logic                i_ready
);
    import lsd_pkg::*;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
    localparam logic [TERM_W-1:0] TERM_MAX  = TERM_W'(MAX_TERMS);

    // saturating output scale of one coordinate: {sat, value}
    function automatic logic [32:0] scale_fin(input logic [47:0] hi, input logic [63:0] lo,
                                              input logic neg);
        logic [41:0] res;
        logic [41:0] lim;
        logic        sat;
        logic [31:0] v;
        lim = neg ? 42'h0_8000_0000 : 42'h0_7FFF_FFFF;
        res = {hi[33:0], 8'd0} + {2'd0, lo[63:24]};
        sat = 1'b0;
        if (hi >= 48'h80_0000) begin
            res = lim;
            sat = 1'b1;
        end else if (res > lim) begin
            res = lim;
            sat = 1'b1;
        end
        v = neg ? (32'd0 - res[31:0]) : res[31:0];
        return {sat, v};
    endfunction

    // item and cordic registers
    logic        [23:0]       r_r;
    logic        [1:0]        r_q;
    logic signed [33:0]       r_x, r_y, r_z, r_c, r_s;
    logic        [STEP_W-1:0] r_step;
    logic        [TERM_W-1:0] r_n, r_term;
    logic        [27:0]       r_rf;

    // series registers
    logic signed [28:0] r_pre, r_pim;
    logic signed [35:0] r_pw_re, r_pw_im;
    logic signed [63:0] r_acc1, r_acc2;
    logic signed [64:0] r_mrr, r_mii, r_mri, r_mir;
    logic signed [59:0] r_fa, r_fb;

    // scaling registers
    logic [47:0] r_hi1, r_hi2;
    logic [63:0] r_lo1, r_lo2;
    logic        r_neg1, r_neg2;

    // result register
    logic signed [31:0] r_ox, r_oy;
    logic               r_osat, r_ovalid;

    // load-time values
    logic [31:0] ang_a, ang_sum, z32;
    logic [1:0]  ang_q;
    logic [TERM_W-1:0] n_eff;
    always_comb begin
        ang_a   = {i_angle, 16'd0};
        ang_sum = ang_a + 32'h2000_0000;
        ang_q   = ang_sum[31:30];
        z32     = ang_a - {ang_q, 30'd0};
        n_eff   = ({1'b0, i_cfg.term_count} > TERM_MAX) ? TERM_MAX
                                                        : {1'b0, i_cfg.term_count};
    end

    // cordic step
    logic signed [33:0] dx, dy, at;
    always_comb begin
        dx = r_y >>> r_step[4:0];
        dy = r_x >>> r_step[4:0];
        at = $signed({2'b00, atan_turn(r_step[4:0])});
    end

    // ratio r/R clamped to 8.0
    logic [55:0] rf_full;
    assign rf_full = r_r * i_cfg.inv_lens_radius;

    // base term p and accumulator start
    logic signed [62:0] prc, prs;
    logic signed [32:0] fr, fs;
    logic signed [33:0] nfr;
    logic signed [28:0] pre_c, pim_c;
    logic signed [58:0] arc, ars;
    always_comb begin
        prc = $signed({1'b0, r_rf}) * r_c;
        prs = $signed({1'b0, r_rf}) * r_s;
        fr  = prc[62:30];
        fs  = prs[62:30];
        nfr = -{fr[32], fr};
        if (nfr > 34'sd134217728) begin
            pre_c = 29'sd134217728;
        end else if (nfr < -34'sd134217728) begin
            pre_c = -29'sd134217728;
        end else begin
            pre_c = nfr[28:0];
        end
        if (fs > 33'sd134217728) begin
            pim_c = 29'sd134217728;
        end else if (fs < -33'sd134217728) begin
            pim_c = -29'sd134217728;
        end else begin
            pim_c = fs[28:0];
        end
        arc = $signed({1'b0, r_r}) * r_c;
        ars = $signed({1'b0, r_r}) * r_s;
    end

    // power update and accumulation
    logic signed [65:0] sre, sim;
    logic signed [41:0] nre, nim;
    logic signed [35:0] pw_re_c, pw_im_c;
    logic signed [64:0] a1, a2;
    logic signed [63:0] acc1_c, acc2_c;
    localparam logic signed [64:0] ACC_LIM = 65'sd4611686018427387904;
    always_comb begin
        sre = {r_mrr[64], r_mrr} - {r_mii[64], r_mii};
        sim = {r_mri[64], r_mri} + {r_mir[64], r_mir};
        nre = sre[65:24];
        nim = sim[65:24];
        if (nre > 42'sd17179869184) begin
            pw_re_c = 36'sd17179869184;
        end else if (nre < -42'sd17179869184) begin
            pw_re_c = -36'sd17179869184;
        end else begin
            pw_re_c = nre[35:0];
        end
        if (nim > 42'sd17179869184) begin
            pw_im_c = 36'sd17179869184;
        end else if (nim < -42'sd17179869184) begin
            pw_im_c = -36'sd17179869184;
        end else begin
            pw_im_c = nim[35:0];
        end
        a1 = {r_acc1[63], r_acc1} - 65'(r_fa);
        a2 = {r_acc2[63], r_acc2} - 65'(r_fb);
        if (a1 > ACC_LIM) begin
            acc1_c = ACC_LIM[63:0];
        end else if (a1 < -ACC_LIM) begin
            acc1_c = -(ACC_LIM[63:0]);
        end else begin
            acc1_c = a1[63:0];
        end
        if (a2 > ACC_LIM) begin
            acc2_c = ACC_LIM[63:0];
        end else if (a2 < -ACC_LIM) begin
            acc2_c = -(ACC_LIM[63:0]);
        end else begin
            acc2_c = a2[63:0];
        end
    end

    // magnitude of the lens value
    logic signed [47:0] v1, v2;
    logic        [47:0] mag1, mag2;
    always_comb begin
        v1   = r_acc1[63:16];
        v2   = r_acc2[63:16];
        mag1 = v1[47] ? 48'(-v1) : 48'(v1);
        mag2 = v2[47] ? 48'(-v2) : 48'(v2);
    end

    logic [32:0] fin1, fin2;
    assign fin1 = scale_fin(r_hi1, r_lo1, r_neg1);
    assign fin2 = scale_fin(r_hi2, r_lo2, r_neg2);

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_r    <= i_radius;
            r_q    <= ang_q;
            r_z    <= 34'(signed'(z32));
            r_x    <= CORDIC_X0;
            r_y    <= '0;
            r_step <= '0;
            r_n    <= n_eff;
        end
        if (i_cmd.cordic) begin
            if (!r_z[33]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
            r_step <= r_step + 1'b1;
        end
        if (i_cmd.quad) begin
            case (r_q)
                2'd1: begin
                    r_c <= -r_y;
                    r_s <= r_x;
                end
                2'd2: begin
                    r_c <= -r_x;
                    r_s <= -r_y;
                end
                2'd3: begin
                    r_c <= r_y;
                    r_s <= -r_x;
                end
                default: begin
                    r_c <= r_x;
                    r_s <= r_y;
                end
            endcase
            r_rf <= (rf_full[55:12] > 44'd134217728) ? 28'd134217728 : rf_full[39:12];
        end
        if (i_cmd.pgen) begin
            r_pre   <= pre_c;
            r_pim   <= pim_c;
            r_pw_re <= 36'(pre_c);
            r_pw_im <= 36'(pim_c);
            r_acc1  <= 64'($signed(arc[58:10]));
            r_acc2  <= 64'($signed(ars[58:10]));
            r_term  <= '0;
        end
        if (i_cmd.term_mul) begin
            r_mrr <= r_pw_re * r_pre;
            r_mii <= r_pw_im * r_pim;
            r_mri <= r_pw_re * r_pim;
            r_mir <= r_pw_im * r_pre;
            r_fa  <= i_cfg.lens_coefficient * $signed(r_pw_re[35:8]);
            r_fb  <= i_cfg.lens_coefficient * $signed(r_pw_im[35:8]);
        end
        if (i_cmd.term_add) begin
            r_pw_re <= pw_re_c;
            r_pw_im <= pw_im_c;
            r_acc1  <= acc1_c;
            r_acc2  <= acc2_c;
            r_term  <= r_term + 1'b1;
        end
        if (i_cmd.scale_mul) begin
            r_hi1  <= mag1[47:32] * i_cfg.inv_chi;
            r_lo1  <= mag1[31:0] * i_cfg.inv_chi;
            r_neg1 <= v1[47];
            r_hi2  <= mag2[47:32] * i_cfg.inv_chi;
            r_lo2  <= mag2[31:0] * i_cfg.inv_chi;
            r_neg2 <= v2[47];
        end
        if (i_cmd.scale_fin) begin
            r_ox   <= fin1[31:0];
            r_oy   <= fin2[31:0];
            r_osat <= fin1[32] | fin2[32];
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.scale_fin) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // status back to the controller
    assign o_stat.cordic_last = (r_step == STEP_LAST);
    assign o_stat.no_terms    = (r_n == '0);
    assign o_stat.term_last   = (r_term == r_n - 1'b1);
    assign o_stat.out_free    = !r_ovalid || i_ready;

    assign o_source_x  = r_ox;
    assign o_source_y  = r_oy;
    assign o_saturated = r_osat;
    assign o_valid     = r_ovalid;

endmodule

>>> sv/lens_series_distortion_unit.sv
// top level of the lens series distortion unit: register file, controller and datapath
// Maps a lens-plane point (radius, angle) to its source-plane point through a
// truncated point-mass lens series, scaled by 1/chi and saturated to Q16.16.
// Slave stream takes one item per point; master stream returns one item per point.
// Configuration writes go through the cfg channel (always ready), index 0..3:
// inv_lens_radius, lens_coefficient, inv_chi, term_count; other indexes are dropped.
// Only write configuration while the block is idle.
// An item is loaded, then rotated by the iterative cordic, folded into its quadrant,
// turned into the base term, run through the series loop for n terms, where n is
// term_count limited to MAX_TERMS, scaled and saturated; the next item is taken only
// once the block is back in idle. Each term of the series loop is a complex
// multiply-accumulate step split into a multiply state and an add state.
// The result sits in an output register: while the receiver stalls, the next item
// is still accepted and computed, and waits in its last step until the slot frees.
// Reset clears the controller and result valid, and restores the register defaults
// (inv_chi = 1.0, term_count = 16, others zero).
module lens_series_distortion_unit #(
    parameter int MAX_TERMS    = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // radius [23:0], angle [39:24]
    // result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // source_x [31:0], source_y [63:32]
    output logic [0:0]  o_m_tuser,   // saturated [0]
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import lsd_pkg::*;

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;
    logic signed [31:0] src_x, src_y;
    logic               sat;

    assign o_cfg_ready = 1'b1;

    // configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_lens_radius  <= 32'd0;
            r_cfg.lens_coefficient <= 32'sd0;
            r_cfg.inv_chi          <= 32'd16777216;
            r_cfg.term_count       <= 6'd16;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INV_LENS_RADIUS:  r_cfg.inv_lens_radius  <= i_cfg_data;
                CFG_LENS_COEFFICIENT: r_cfg.lens_coefficient <= i_cfg_data;
                CFG_INV_CHI:          r_cfg.inv_chi          <= i_cfg_data;
                CFG_TERM_COUNT:       r_cfg.term_count       <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // controller
    lsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath
    lsd_dpath #(
        .MAX_TERMS    (MAX_TERMS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg       (r_cfg),
        .i_radius    (i_s_tdata[23:0]),
        .i_angle     (i_s_tdata[39:24]),
        .o_source_x  (src_x),
        .o_source_y  (src_y),
        .o_saturated (sat),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready)
    );

    assign o_m_tdata    = {src_y, src_x};
    assign o_m_tuser[0] = sat;

endmodule

>>> dv/lens_series_distortion_unit_tb.sv
// testbench of the lens series distortion unit: directed and random points checked against a predictor
module lens_series_distortion_unit_tb;
    import lsd_pkg::*;

    localparam int MAX_TERMS    = 32;
    localparam int CORDIC_STEPS = 16;
    localparam longint RF_LIM   = 64'sd1 << 27;
    localparam longint POW_LIM  = 64'sd1 << 34;
    localparam longint ACC_LIM  = 64'sd1 << 62;
    localparam longint CYCLE_LIMIT = 2000000;

    // expected source point of one item
    typedef struct packed {
        logic signed [31:0] src_x;
        logic signed [31:0] src_y;
        logic               sat;
    } t_point;

    // queue of expected source points and failure tracking
    class point_scoreboard;
        t_point pending[$];
        int     errors;

        function void note(t_point p);
            pending.push_back(p);
        endfunction

        function void check(t_point got);
            t_point want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected item x=%h y=%h sat=%b", $time, got.src_x, got.src_y,
                         got.sat);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.src_x !== want.src_x) begin
                $display("%0t: source_x expected %h actual %h", $time, want.src_x, got.src_x);
                errors++;
            end
            if (got.src_y !== want.src_y) begin
                $display("%0t: source_y expected %h actual %h", $time, want.src_y, got.src_y);
                errors++;
            end
            if (got.sat !== want.sat) begin
                $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    logic [63:0] o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    lens_series_distortion_unit #(.MAX_TERMS(MAX_TERMS), .CORDIC_STEPS(CORDIC_STEPS)) dut (
        .i_clk, .i_rst_n, .i_s_tvalid, .o_s_tready, .i_s_tdata,
        .o_m_tvalid, .i_m_tready, .o_m_tdata, .o_m_tuser,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    always #5 i_clk = ~i_clk;

    point_scoreboard sb = new();

    // shadow registers of the block
    logic [31:0] inv_radius_reg = 32'd0;
    logic [31:0] coef_reg       = 32'd0;
    logic [31:0] inv_chi_reg    = 32'd16777216;
    logic [5:0]  terms_reg      = 6'd16;

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // fixed-length rotation giving cos and sin in q.30
    function automatic void rotate(logic [15:0] ang, output longint c, output longint s);
        logic [31:0] a;
        logic [1:0]  q;
        longint z, x, y, dx, dy, t;
        a = {ang, 16'd0};
        q = 2'((a + 32'h20000000) >> 30);
        z = longint'(a) - (longint'(q) << 30);
        if (z >= (64'sd1 << 31)) z -= 64'sd1 << 32;
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_turn(5'(i)));
            end else begin
                x += dx; y -= dy; z += longint'(atan_turn(5'(i)));
            end
        end
        case (q)
            2'd1: begin t = x; x = -y; y = t; end
            2'd2: begin x = -x; y = -y; end
            2'd3: begin t = x; x = y; y = -t; end
            default: ;
        endcase
        c = x;
        s = y;
    endfunction

    // scale by 1/chi with magnitude truncation and saturation
    function automatic logic [31:0] scale_chi(longint v, logic [31:0] k, inout logic sat);
        logic        neg;
        logic [63:0] mag, hi, lo, lim, res;
        neg = v < 0;
        mag = neg ? 64'(-v) : 64'(v);
        hi  = (mag >> 32) * 64'(k);
        lo  = (mag & 64'hFFFFFFFF) * 64'(k);
        lim = neg ? 64'h80000000 : 64'h7FFFFFFF;
        if (hi >= (64'd1 << 23)) begin
            res = lim; sat = 1;
        end else begin
            res = (hi << 8) + (lo >> 24);
            if (res > lim) begin
                res = lim; sat = 1;
            end
        end
        return neg ? 32'(-res) : 32'(res);
    endfunction

    function automatic t_point predict_source(logic [23:0] radius, logic [15:0] ang);
        longint r, c, s, rf, pre, pim, pr, pi, a1, a2, nr, ni, frac;
        int     n;
        logic   sat;
        t_point p;
        r    = longint'(radius);
        frac = longint'(signed'(coef_reg));
        n    = terms_reg > MAX_TERMS ? MAX_TERMS : int'(terms_reg);
        sat  = 0;
        rotate(ang, c, s);
        rf = longint'((64'(radius) * 64'(inv_radius_reg)) >> 12);
        if (rf > RF_LIM) rf = RF_LIM;
        pre = clamp(-fshift(rf * c, 30), RF_LIM);
        pim = clamp(fshift(rf * s, 30), RF_LIM);
        a1 = fshift(r * c, 10);
        a2 = fshift(r * s, 10);
        pr = pre;
        pi = pim;
        for (int m = 0; m < n; m++) begin
            a1 = clamp(a1 - frac * fshift(pr, 8), ACC_LIM);
            a2 = clamp(a2 - frac * fshift(pi, 8), ACC_LIM);
            nr = fshift(pr * pre - pi * pim, 24);
            ni = fshift(pr * pim + pi * pre, 24);
            pr = clamp(nr, POW_LIM);
            pi = clamp(ni, POW_LIM);
        end
        p.src_x = scale_chi(fshift(a1, 16), inv_chi_reg, sat);
        p.src_y = scale_chi(fshift(a2, 16), inv_chi_reg, sat);
        p.sat   = sat;
        return p;
    endfunction

    // cycle counter and timeout
    longint cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    bit burst_mode = 0;

    // result side: random stalls, check on accept
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                sb.check({o_m_tdata[31:0], o_m_tdata[63:32], o_m_tuser[0]});
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_m_tready <= 0;
            end else if (o_m_tvalid && i_m_tready) begin
                if (burst_mode) begin
                    stall_left <= 0;
                    i_m_tready <= 1;
                end else begin
                    stall_left <= $urandom_range(0, 13);
                    i_m_tready <= 0;
                end
            end else begin
                i_m_tready <= 1;
            end
        end
    end

    // register writes wait until no item is in flight
    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        i_s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        case (idx)
            CFG_INV_LENS_RADIUS:  inv_radius_reg = val;
            CFG_LENS_COEFFICIENT: coef_reg = val;
            CFG_INV_CHI:          inv_chi_reg = val;
            CFG_TERM_COUNT:       terms_reg = val[5:0];
            default: ;
        endcase
    endtask

    // valid stays high into a back-to-back item and drops only before a gap
    task automatic send_point(logic [23:0] radius, logic [15:0] ang);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_s_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata  <= {ang, radius};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note(predict_source(radius, ang));
    endtask

    // wait for all results, then let the block settle
    task automatic drain();
        i_s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic random_points(int count);
        logic [23:0] r;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 3))
                0: r = 24'($urandom);
                1: r = 24'($urandom_range(0, 8191));
                2: r = 24'($urandom_range(0, 255)) << $urandom_range(0, 16);
                default: r = 24'($urandom_range(2048, 16384));
            endcase
            send_point(r, 16'($urandom));
        end
    endtask

    task automatic random_config(bit small_terms);
        case ($urandom_range(0, 2))
            0: write_reg(CFG_INV_LENS_RADIUS, $urandom);
            1: write_reg(CFG_INV_LENS_RADIUS, $urandom_range(0, 32'h00FFFFFF));
            default: write_reg(CFG_INV_LENS_RADIUS, 32'h0100_0000 >> $urandom_range(0, 12));
        endcase
        case ($urandom_range(0, 2))
            0: write_reg(CFG_LENS_COEFFICIENT, $urandom);
            1: write_reg(CFG_LENS_COEFFICIENT, 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)));
            default: write_reg(CFG_LENS_COEFFICIENT, 32'h0001_0000);
        endcase
        case ($urandom_range(0, 2))
            0: write_reg(CFG_INV_CHI, $urandom);
            1: write_reg(CFG_INV_CHI, $urandom_range(0, 32'h0200_0000));
            default: write_reg(CFG_INV_CHI, 32'h0100_0000);
        endcase
        write_reg(CFG_TERM_COUNT, small_terms ? $urandom_range(0, 6) : $urandom_range(0, 63));
    endtask

    initial begin
        logic [15:0] angles[8];
        angles = '{16'h0000, 16'h2000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h1FFF,
                   16'h6000};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset defaults, extremes of both fields and every quadrant
        send_point(24'd0, 16'd0);
        send_point(24'hFFFFFF, 16'hFFFF);
        foreach (angles[i]) send_point(24'h001000, angles[i]);
        drain();

        // large ratio, power and accumulator clamps, output saturation
        write_reg(CFG_INV_LENS_RADIUS, 32'hFFFFFFFF);
        write_reg(CFG_LENS_COEFFICIENT, 32'h7FFFFFFF);
        write_reg(CFG_INV_CHI, 32'hFFFFFFFF);
        write_reg(CFG_TERM_COUNT, 6'd63);
        send_point(24'hFFFFFF, 16'h1234);
        send_point(24'h000800, 16'hA000);
        write_reg(CFG_LENS_COEFFICIENT, 32'h80000000);
        send_point(24'hFFFFFF, 16'h5555);
        send_point(24'h000001, 16'h8000);
        drain();

        // no terms, single term, zero scale, unknown register index ignored
        write_reg(CFG_TERM_COUNT, 6'd0);
        write_reg(8'd7, 32'hDEADBEEF);
        write_reg(8'hFF, 32'h12345678);
        send_point(24'hFFFFFF, 16'h3000);
        write_reg(CFG_TERM_COUNT, 6'd1);
        write_reg(CFG_INV_CHI, 32'd0);
        send_point(24'h123456, 16'h9ABC);
        write_reg(CFG_INV_CHI, 32'h0100_0000);
        write_reg(CFG_INV_LENS_RADIUS, 32'h0080_0000);
        write_reg(CFG_LENS_COEFFICIENT, 32'h0001_0000);
        send_point(24'h001800, 16'h0800);
        drain();

        // random phases, mostly few terms, with stall-free bursts between
        for (int ph = 0; ph < 27; ph++) begin
            random_config(ph % 4 != 3);
            burst_mode = (ph % 5 == 2);
            random_points(50);
            drain();
        end
        burst_mode = 0;

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
